>>> sv/page_table_walker_top_macros.svh
// Assertion helpers for the page table walker.
`ifndef PAGE_TABLE_WALKER_TOP_MACROS_SVH
`define PAGE_TABLE_WALKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PTW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page table walker: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page table walker: assertion failed");

`endif

>>> sv/ptw_pkg.sv
package ptw_pkg;

    localparam int VA_W = 48;
    localparam int PA_W = 52;
    localparam int IDX_W = 9;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE_BASE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_ADDRESS_OFFSET = 1'b1;

    // Entry awaited during a walk
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    typedef enum logic {
        FUNC_TRANSLATE = 1'b0,
        FUNC_ENTRY     = 1'b1
    } t_func;

    typedef enum logic {
        RES_READ  = 1'b0,
        RES_FINAL = 1'b1
    } t_res_kind;

    typedef enum logic {
        TBL_ROOT  = 1'b0,
        TBL_ENTRY = 1'b1
    } t_tbl_sel;

    typedef enum logic [1:0] {
        PG_NONE = 2'd0,
        PG_1G   = 2'd1,
        PG_2M   = 2'd2,
        PG_4K   = 2'd3
    } t_page_sel;

    typedef struct packed {
        logic      load_virt;
        logic      emit;
        t_res_kind kind;
        t_tbl_sel  tbl_sel;
        t_page_sel page_sel;
        logic [1:0] idx_level;
    } t_dp_cmd;

    typedef struct packed {
        logic present;
        logic page_size;
    } t_dp_sts;

endpackage

>>> sv/ptw_req_if.sv
interface ptw_req_if;
    import ptw_pkg::*;

    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] virt_addr;
    logic [63:0] read_data;

    modport source (output valid, output func, output virt_addr, output read_data,
                    input ready);
    modport sink (input valid, input func, input virt_addr, input read_data,
                  output ready);
endinterface

>>> sv/ptw_rsp_if.sv
interface ptw_rsp_if;
    import ptw_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic [63:0]     mem_addr;
    logic [PA_W-1:0] phys_addr;
    logic            mapped;

    modport source (output valid, output kind, output mem_addr, output phys_addr,
                    output mapped, input ready);
    modport sink (input valid, input kind, input mem_addr, input phys_addr,
                  input mapped, output ready);
endinterface

>>> sv/ptw_ctrl.sv
module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_func,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_level, n_level;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_busy      = (r_state == ST_WALK);

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.load_virt = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.kind      = RES_READ;
        o_cmd.tbl_sel   = TBL_ROOT;
        o_cmd.page_sel  = PG_NONE;
        o_cmd.idx_level = LVL_PML4;
        if (w_accept) begin
            case (r_state)
                ST_IDLE: begin
                    // entry data while idle is dropped
                    if (i_func == FUNC_TRANSLATE) begin
                        o_cmd.load_virt = 1'b1;
                        o_cmd.emit      = 1'b1;
                        n_out_valid     = 1'b1;
                        n_state         = ST_WALK;
                        n_level         = LVL_PML4;
                    end
                end
                ST_WALK: begin
                    // translate while walking is dropped
                    if (i_func == FUNC_ENTRY) begin
                        o_cmd.emit  = 1'b1;
                        n_out_valid = 1'b1;
                        if (!i_sts.present) begin
                            o_cmd.kind = RES_FINAL;
                        end else if (r_level == LVL_PDPT && i_sts.page_size) begin
                            o_cmd.kind     = RES_FINAL;
                            o_cmd.page_sel = PG_1G;
                        end else if (r_level == LVL_PD && i_sts.page_size) begin
                            o_cmd.kind     = RES_FINAL;
                            o_cmd.page_sel = PG_2M;
                        end else if (r_level == LVL_PT) begin
                            o_cmd.kind     = RES_FINAL;
                            o_cmd.page_sel = PG_4K;
                        end else begin
                            o_cmd.tbl_sel   = TBL_ENTRY;
                            o_cmd.idx_level = r_level + 2'd1;
                            n_level         = r_level + 2'd1;
                        end
                        if (o_cmd.kind == RES_FINAL) begin
                            n_state = ST_IDLE;
                            n_level = LVL_PML4;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= LVL_PML4;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/ptw_dp.sv
module ptw_dp
    import ptw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic [63:0]          i_virt_addr,
    input  logic [63:0]          i_read_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_kind,
    output logic [63:0]          o_mem_addr,
    output logic [PA_W-1:0]      o_phys_addr,
    output logic                 o_mapped
);

    logic [63:0]     r_root_base;
    logic [63:0]     r_offset;
    logic [VA_W-1:0] r_saved_virt;
    logic            r_kind;
    logic [63:0]     r_mem_addr;
    logic [PA_W-1:0] r_phys_addr;
    logic            r_mapped;

    logic [IDX_W-1:0] w_idx;
    logic [51:0]      w_table;
    logic [63:0]      w_mem_addr;
    logic [PA_W-1:0]  w_phys;

    assign o_sts.present   = i_read_data[BIT_PRESENT];
    assign o_sts.page_size = i_read_data[BIT_LARGE];

    // Table index for the entry to fetch; the root index comes straight off the request
    always_comb begin
        case (i_cmd.idx_level)
            LVL_PML4: w_idx = i_cmd.load_virt ? i_virt_addr[47:39] : r_saved_virt[47:39];
            LVL_PDPT: w_idx = r_saved_virt[38:30];
            LVL_PD:   w_idx = r_saved_virt[29:21];
            LVL_PT:   w_idx = r_saved_virt[20:12];
            default:  w_idx = r_saved_virt[47:39];
        endcase
    end

    // Tables are 4 KiB aligned, so the index slots in below the frame number
    assign w_table    = (i_cmd.tbl_sel == TBL_ROOT) ? r_root_base[63:12]
                                                    : {12'd0, i_read_data[51:12]};
    assign w_mem_addr = r_offset + {w_table, w_idx, 3'b000};

    always_comb begin
        case (i_cmd.page_sel)
            PG_1G:   w_phys = {i_read_data[51:30], r_saved_virt[29:0]};
            PG_2M:   w_phys = {i_read_data[51:21], r_saved_virt[20:0]};
            PG_4K:   w_phys = {i_read_data[51:12], r_saved_virt[11:0]};
            default: w_phys = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_base <= '0;
            r_offset    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROOT_TABLE_BASE:     r_root_base <= i_cfg_data;
                CFG_READ_ADDRESS_OFFSET: r_offset    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_virt) begin
            r_saved_virt <= i_virt_addr[VA_W-1:0];
        end
        if (i_cmd.emit) begin
            r_kind <= i_cmd.kind;
            if (i_cmd.kind == RES_READ) begin
                r_mem_addr  <= w_mem_addr;
                r_phys_addr <= '0;
                r_mapped    <= 1'b0;
            end else begin
                r_mem_addr  <= '0;
                r_phys_addr <= w_phys;
                r_mapped    <= (i_cmd.page_sel != PG_NONE);
            end
        end
    end

    assign o_kind      = r_kind;
    assign o_mem_addr  = r_mem_addr;
    assign o_phys_addr = r_phys_addr;
    assign o_mapped    = r_mapped;

endmodule

>>> sv/page_table_walker_top.sv
// Four-level x86-64 page table walker. A translate request (func 0) latches the
// low 48 bits of the virtual address and sends out a read request for the root
// entry at read_address_offset + root_table_base[63:12]*4096 + index*8. Each
// entry returned on the same input channel (func 1) either yields the next read
// request or a final result: a 4 KiB, 2 MiB or 1 GiB page with mapped set, or
// phys_addr 0 with mapped clear when an entry is not present. A translate while a
// walk is open, and entry data while idle, are dropped without a result. Every
// accepted request that produces a result shows it on the output register on the
// next cycle; the input takes one request per cycle whenever that register is
// empty or being drained, so sustained rate is one request per cycle, set by the
// single output register. Configuration writes must only land while idle.
`include "page_table_walker_top_macros.svh"

module page_table_walker_top
    import ptw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    ptw_req_if.sink              i_req,
    ptw_rsp_if.source            o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_busy;
    logic    w_in_ready;
    logic    w_out_valid;

    // Walk sequencing: state, level, and the output valid flag
    ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_func      (i_req.func),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_busy      (w_busy),
        .o_cmd       (w_cmd)
    );

    // Address arithmetic, config registers, saved address and output payload
    ptw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_virt_addr (i_req.virt_addr),
        .i_read_data (i_req.read_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_kind      (o_rsp.kind),
        .o_mem_addr  (o_rsp.mem_addr),
        .o_phys_addr (o_rsp.phys_addr),
        .o_mapped    (o_rsp.mapped)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    // A translate taken while idle opens a walk with a read request
    `PTW_ASSERT_NEXT(a_start_walk, i_req.valid && i_req.ready && !w_busy && i_req.func == FUNC_TRANSLATE, w_busy && o_rsp.valid && o_rsp.kind == RES_READ)

    // A not-present entry during a walk closes it with an unmapped result
    `PTW_ASSERT_NEXT(a_not_present, i_req.valid && i_req.ready && w_busy && i_req.func == FUNC_ENTRY && !i_req.read_data[BIT_PRESENT], !w_busy && o_rsp.valid && o_rsp.kind == RES_FINAL && !o_rsp.mapped)

    // Read requests never carry a translation
    `PTW_ASSERT_NOW(a_read_clean, o_rsp.valid && o_rsp.kind == RES_READ, o_rsp.phys_addr == '0 && !o_rsp.mapped)

    // An empty output register never holds back the input
    `PTW_ASSERT_NOW(a_no_stall, !o_rsp.valid, i_req.ready)

endmodule
